// ===== design/reciprocal_counter_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the reciprocal counter sequencer
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef RECIPROCAL_COUNTER_SEQUENCER_ASSERT_SVH
`define RECIPROCAL_COUNTER_SEQUENCER_ASSERT_SVH

// Checked only outside reset.
`define RCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sequencer assertion failed");

// Checked on every edge, reset included.
`define RCS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sequencer reset assertion failed");

`endif

// ===== design/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Reciprocal counter sequencer package
// Phase encoding, control flag bits and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_READY   = 8'b0000_0010,
    PH_TRIGGER = 8'b0000_0100,
    PH_BUSY1   = 8'b0000_1000,
    PH_BUSY2   = 8'b0001_0000,
    PH_BUSY3   = 8'b0010_0000,
    PH_CAL1    = 8'b0100_0000,
    PH_CAL2    = 8'b1000_0000
  } phase_t;

  localparam logic [2:0] CODE_IDLE    = 3'd0;
  localparam logic [2:0] CODE_READY   = 3'd1;
  localparam logic [2:0] CODE_TRIGGER = 3'd2;
  localparam logic [2:0] CODE_BUSY1   = 3'd3;
  localparam logic [2:0] CODE_BUSY2   = 3'd4;
  localparam logic [2:0] CODE_BUSY3   = 3'd5;
  localparam logic [2:0] CODE_CAL1    = 3'd6;
  localparam logic [2:0] CODE_CAL2    = 3'd7;

  localparam logic [6:0] FLAG_CLR   = 7'h01;
  localparam logic [6:0] FLAG_START = 7'h02;
  localparam logic [6:0] FLAG_STOP  = 7'h04;
  localparam logic [6:0] FLAG_TEST  = 7'h08;
  localparam logic [6:0] FLAG_CALZ  = 7'h10;
  localparam logic [6:0] FLAG_CALF  = 7'h20;
  localparam logic [6:0] FLAG_MCLR  = 7'h40;

  localparam logic [2:0] CFG_DURATION_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_BURST_MODE      = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD_ONE   = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD_TWO   = 3'd3;
  localparam logic [2:0] CFG_COUPLING_SELECT = 3'd4;
  localparam logic [2:0] CFG_EDGE_SELECT     = 3'd5;

  localparam logic [7:0] DAC_FULL_SCALE = 8'd255;

  function automatic logic [2:0] phase_code(phase_t p);
    logic [2:0] code;
    case (p)
      PH_IDLE:    code = CODE_IDLE;
      PH_READY:   code = CODE_READY;
      PH_TRIGGER: code = CODE_TRIGGER;
      PH_BUSY1:   code = CODE_BUSY1;
      PH_BUSY2:   code = CODE_BUSY2;
      PH_BUSY3:   code = CODE_BUSY3;
      PH_CAL1:    code = CODE_CAL1;
      PH_CAL2:    code = CODE_CAL2;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== design/reciprocal_counter_sequencer.sv =====
// ----------------------------------------------------------------------------
// Reciprocal counter sequencer
// Steps the gate, capture and calibration sequence of a reciprocal frequency
// counter once per front-end poll and reports control and capture results.
//
//   Channel   Signals                               Direction
//   poll      in_valid, in_stall, trigger..interp   in (stall driven out)
//   result    out_valid, out_stall, measure_phase.. out (stall driven in)
//   config    cfg_we, cfg_index, cfg_data           in
//
// One poll is taken per cycle unless in_stall is high; its result passes
// the poll register, then the result register; both let one poll enter
// while a result waits. The phase step is compares and byte subtracts.
// Reset clears the configuration, phase and capture state and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reciprocal_counter_sequencer_assert.svh"

module reciprocal_counter_sequencer
  import rcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        trigger,
  input  wire logic [31:0] now_ticks,
  input  wire logic        ack_started,
  input  wire logic        ack_stopped,
  input  wire logic [31:0] count_value,
  input  wire logic [31:0] timer_value,
  input  wire logic [7:0]  start_interp,
  input  wire logic [7:0]  stop_interp,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       measure_phase,
  output logic [6:0]       control_flags,
  output logic [7:0]       dac_one_level,
  output logic [7:0]       dac_two_level,
  output logic [9:0]       front_setup,
  output logic [31:0]      captured_count,
  output logic [31:0]      captured_timer,
  output logic [7:0]       start_dividend,
  output logic [7:0]       start_divisor,
  output logic [7:0]       stop_dividend,
  output logic [7:0]       stop_divisor
);

  logic [15:0] duration_limit;
  logic        burst_mode;
  logic [7:0]  threshold_one;
  logic [7:0]  threshold_two;
  logic [1:0]  coupling_select;
  logic [7:0]  edge_select;

  logic        s1_valid;
  logic        s1_trigger;
  logic [31:0] s1_now;
  logic        s1_started;
  logic        s1_stopped;
  logic [31:0] s1_count;
  logic [31:0] s1_timer;
  logic [7:0]  s1_start_interp;
  logic [7:0]  s1_stop_interp;

  phase_t      phase;
  phase_t      phase_next;
  phase_t      cur;
  logic [31:0] last_change;
  logic [31:0] last_change_next;
  logic [31:0] held_count;
  logic [31:0] held_count_next;
  logic [31:0] held_timer;
  logic [31:0] held_timer_next;
  logic [7:0]  start_raw;
  logic [7:0]  start_raw_next;
  logic [7:0]  stop_raw;
  logic [7:0]  stop_raw_next;
  logic [7:0]  start_zero;
  logic [7:0]  start_zero_next;
  logic [7:0]  stop_zero;
  logic [7:0]  stop_zero_next;
  logic [7:0]  start_full;
  logic [7:0]  start_full_next;
  logic [7:0]  stop_full;
  logic [7:0]  stop_full_next;
  logic [6:0]  flags_next;
  logic [6:0]  arm;
  logic [31:0] elapsed;
  logic        expired;
  logic        ready;
  logic        advance;
  logic        in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_limit  <= '0;
      burst_mode      <= 1'b0;
      threshold_one   <= '0;
      threshold_two   <= '0;
      coupling_select <= '0;
      edge_select     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DURATION_LIMIT:  duration_limit  <= cfg_data;
        CFG_BURST_MODE:      burst_mode      <= cfg_data[0];
        CFG_THRESHOLD_ONE:   threshold_one   <= cfg_data[7:0];
        CFG_THRESHOLD_TWO:   threshold_two   <= cfg_data[7:0];
        CFG_COUPLING_SELECT: coupling_select <= cfg_data[1:0];
        CFG_EDGE_SELECT:     edge_select     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_trigger      <= trigger;
      s1_now          <= now_ticks;
      s1_started      <= ack_started;
      s1_stopped      <= ack_stopped;
      s1_count        <= count_value;
      s1_timer        <= timer_value;
      s1_start_interp <= start_interp;
      s1_stop_interp  <= stop_interp;
    end
  end

  assign ready   = s1_started && s1_stopped;
  assign arm     = burst_mode ? FLAG_START : (FLAG_START | FLAG_STOP);
  assign elapsed = s1_now - last_change;
  assign expired = elapsed >= {16'd0, duration_limit};
  assign cur     = s1_trigger ? PH_TRIGGER : phase;

  always_comb begin
    phase_next      = PH_IDLE;
    flags_next      = FLAG_MCLR | FLAG_CLR;
    held_count_next = held_count;
    held_timer_next = held_timer;
    start_raw_next  = start_raw;
    stop_raw_next   = stop_raw;
    start_zero_next = start_zero;
    stop_zero_next  = stop_zero;
    start_full_next = start_full;
    stop_full_next  = stop_full;
    unique case (cur)
      PH_IDLE, PH_READY: begin
        phase_next = cur;
      end
      PH_TRIGGER: begin
        phase_next = PH_BUSY1;
        flags_next = FLAG_MCLR | arm;
      end
      PH_BUSY1: begin
        if (!expired) begin
          if (!s1_started) begin
            phase_next = PH_BUSY1;
            flags_next = arm;
          end else begin
            phase_next = PH_BUSY2;
            flags_next = arm | FLAG_TEST;
          end
        end
      end
      PH_BUSY2: begin
        if (!expired && !ready) begin
          phase_next = PH_BUSY2;
          flags_next = arm | FLAG_TEST;
        end else begin
          phase_next = PH_BUSY3;
          flags_next = FLAG_START | FLAG_STOP | FLAG_TEST;
        end
      end
      PH_BUSY3: begin
        if (!expired) begin
          if (!ready) begin
            phase_next = PH_BUSY3;
            flags_next = FLAG_START | FLAG_STOP | FLAG_TEST;
          end else begin
            held_count_next = s1_count;
            held_timer_next = s1_timer;
            start_raw_next  = s1_start_interp;
            stop_raw_next   = s1_stop_interp;
            phase_next      = PH_CAL1;
            flags_next      = FLAG_MCLR | FLAG_CALZ;
          end
        end
      end
      PH_CAL1: begin
        if (ready) begin
          start_zero_next = s1_start_interp;
          stop_zero_next  = s1_stop_interp;
          phase_next      = PH_CAL2;
          flags_next      = FLAG_MCLR | FLAG_CALF;
        end
      end
      PH_CAL2: begin
        if (ready) begin
          start_full_next = s1_start_interp;
          stop_full_next  = s1_stop_interp;
          phase_next      = PH_READY;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    last_change_next = (phase_next != cur) ? s1_now : last_change;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      last_change <= '0;
      held_count  <= '0;
      held_timer  <= '0;
      start_raw   <= '0;
      stop_raw    <= '0;
      start_zero  <= '0;
      stop_zero   <= '0;
      start_full  <= '0;
      stop_full   <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      last_change <= last_change_next;
      held_count  <= held_count_next;
      held_timer  <= held_timer_next;
      start_raw   <= start_raw_next;
      stop_raw    <= stop_raw_next;
      start_zero  <= start_zero_next;
      stop_zero   <= stop_zero_next;
      start_full  <= start_full_next;
      stop_full   <= stop_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      measure_phase  <= phase_code(phase_next);
      control_flags  <= flags_next;
      dac_one_level  <= DAC_FULL_SCALE - threshold_one;
      dac_two_level  <= DAC_FULL_SCALE - threshold_two;
      front_setup    <= {coupling_select, edge_select};
      start_dividend <= start_raw_next - start_zero_next;
      start_divisor  <= start_full_next - start_zero_next;
      stop_dividend  <= stop_raw_next - stop_zero_next;
      stop_divisor   <= stop_full_next - stop_zero_next;
    end
  end

  assign captured_count = held_count;
  assign captured_timer = held_timer;

  `RCS_ASSERT(a_stall_only_when_full, in_stall |-> (s1_valid && out_valid && out_stall))
  `RCS_ASSERT(a_advance_loads_result, advance |=> out_valid)
  `RCS_ASSERT(a_capture_only_on_advance, !advance |=> ($stable(held_count) && $stable(phase)))
  `RCS_ASSERT(a_cal_entry_flags, (advance && phase_next == PH_CAL1 && cur == PH_BUSY3)
    |=> (control_flags == (FLAG_MCLR | FLAG_CALZ)))
  `RCS_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !s1_valid))

endmodule

`default_nettype wire
